[hw/rtl/rsov_pkg.sv]
// shared types, constants and helpers for the range sensor obstacle vote block
`default_nettype none

package rsov_pkg;

    // sizing
    localparam int NUM_SENSORS = 8;
    localparam int COUNT_WIDTH = 8;
    localparam int CFG_WIDTH   = 16;
    localparam int CMP_WIDTH   = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;

    typedef logic [COUNT_WIDTH-1:0] cnt_t;
    typedef logic [CMP_WIDTH-1:0]   cmp_t;

    localparam cnt_t       CNT_MAX       = '1;
    localparam logic [3:0] SENSOR_LIMIT  = 4'(NUM_SENSORS);

    // request codes
    typedef enum logic
    {
        REQ_START   = 1'b0,
        REQ_READING = 1'b1
    } req_t;

    // side codes in the sensor map
    typedef enum logic [1:0]
    {
        SIDE_FRONT  = 2'd0,
        SIDE_LEFT   = 2'd1,
        SIDE_RIGHT  = 2'd2,
        SIDE_UNUSED = 2'd3
    } side_t;

    // register indexes
    typedef enum logic [1:0]
    {
        REG_SIDE_MAP     = 2'd0,
        REG_THRESHOLD    = 2'd1,
        REG_MIN_READINGS = 2'd2,
        REG_IDLE_LIMIT   = 2'd3
    } reg_idx_t;

    // reset values of the registers
    localparam logic [15:0] SIDE_MAP_RST     = 16'd0;
    localparam logic [7:0]  THRESHOLD_RST    = 8'd21;
    localparam logic [7:0]  MIN_READINGS_RST = 8'd10;
    localparam logic [7:0]  IDLE_LIMIT_RST   = 8'd5;

    typedef struct packed
    {
        logic [15:0] side_map;
        logic [7:0]  threshold_cm;
        logic [7:0]  min_readings;
        logic [7:0]  idle_limit;
    } cfg_t;

    typedef struct packed
    {
        logic front_blocked;
        logic left_blocked;
        logic right_blocked;
        logic timed_out;
    } verdict_t;

    function automatic cnt_t sat_inc(input cnt_t v);
        return (v == CNT_MAX) ? CNT_MAX : cnt_t'(v + 1'b1);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/rsov_core.sv]
// session state, per-side tallies and verdict logic for one word per cycle while step is high
`default_nettype none

module rsov_core
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic              req_type,
    input  wire logic [2:0]        sensor_id,
    input  wire logic [7:0]        distance_cm,
    input  wire rsov_pkg::cfg_t    cfg,
    output logic                   result_valid,
    output rsov_pkg::verdict_t     result
);

    logic              active_reg, active_next;
    rsov_pkg::cnt_t    idle_run_reg, idle_run_next;
    rsov_pkg::cnt_t    total_reg [3];
    rsov_pkg::cnt_t    total_next [3];
    rsov_pkg::cnt_t    hits_reg [3];
    rsov_pkg::cnt_t    hits_next [3];

    rsov_pkg::side_t   side;
    logic [2:0]        side_full;
    logic [2:0]        blocked;
    logic              idle_stop;
    logic              all_full;
    logic              is_hit;

    always_comb
    begin
        side = rsov_pkg::SIDE_UNUSED;
        if ({1'b0, sensor_id} < rsov_pkg::SENSOR_LIMIT)
        begin
            side = rsov_pkg::side_t'(cfg.side_map[{sensor_id, 1'b0} +: 2]);
        end
    end

    always_comb
    begin
        for (int s = 0; s < 3; s++)
        begin
            side_full[s] = rsov_pkg::cmp_t'(total_reg[s]) >=
                           rsov_pkg::cmp_t'(cfg.min_readings);
            blocked[s]   = hits_reg[s] > (total_reg[s] >> 1);
        end
    end

    assign idle_stop = rsov_pkg::cmp_t'(idle_run_reg) == rsov_pkg::cmp_t'(cfg.idle_limit);
    assign all_full  = &side_full;
    assign is_hit    = distance_cm <= cfg.threshold_cm;

    assign result.front_blocked = blocked[0];
    assign result.left_blocked  = blocked[1];
    assign result.right_blocked = blocked[2];
    assign result.timed_out     = idle_stop;

    always_comb
    begin
        active_next   = active_reg;
        idle_run_next = idle_run_reg;
        total_next    = total_reg;
        hits_next     = hits_reg;
        result_valid  = 1'b0;

        if (step)
        begin
            if (rsov_pkg::req_t'(req_type) == rsov_pkg::REQ_START)
            begin
                for (int s = 0; s < 3; s++)
                begin
                    total_next[s] = '0;
                    hits_next[s]  = '0;
                end
                idle_run_next = '0;
                active_next   = 1'b1;
            end
            else if (active_reg)
            begin
                // stop check sees the tallies before this reading
                if (idle_stop || all_full)
                begin
                    result_valid = 1'b1;
                    active_next  = 1'b0;
                end

                // the stopping reading is still counted
                if (side == rsov_pkg::SIDE_UNUSED)
                begin
                    idle_run_next = rsov_pkg::sat_inc(idle_run_reg);
                end
                else
                begin
                    for (int s = 0; s < 3; s++)
                    begin
                        if (side == rsov_pkg::side_t'(2'(s)))
                        begin
                            idle_run_next = side_full[s] ?
                                            rsov_pkg::sat_inc(idle_run_reg) : '0;
                            total_next[s] = rsov_pkg::sat_inc(total_reg[s]);
                            if (is_hit)
                            begin
                                hits_next[s] = rsov_pkg::sat_inc(hits_reg[s]);
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            idle_run_reg <= '0;
            for (int s = 0; s < 3; s++)
            begin
                total_reg[s] <= '0;
                hits_reg[s]  <= '0;
            end
        end
        else
        begin
            active_reg   <= active_next;
            idle_run_reg <= idle_run_next;
            total_reg    <= total_next;
            hits_reg     <= hits_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/range_sensor_obstacle_vote.sv]
// top level of the range sensor obstacle vote block
// path: the stopping reading word is held in the input register, its verdict in the result register
// throughput: one input word per cycle while no stalled result word holds back the input; the vote
//   logic sits between the input register and the result register and updates its tallies per step
// reset: asynchronous active low; disarms the session, clears all tallies and loads
//   the register defaults; no clearing pass, the block takes words right after reset
`default_nettype none

module range_sensor_obstacle_vote
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        req_type,
    input  wire logic [2:0]  sensor_id,
    input  wire logic [7:0]  distance_cm,

    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             front_blocked,
    output logic             left_blocked,
    output logic             right_blocked,
    output logic             timed_out,

    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [rsov_pkg::CFG_WIDTH-1:0] cfg_data
);

    // input register
    logic                in_valid_reg, in_valid_next;
    logic                req_reg;
    logic [2:0]          sid_reg;
    logic [7:0]          dist_reg;

    // result register
    logic                out_valid_reg, out_valid_next;
    rsov_pkg::verdict_t  verdict_reg;

    // configuration registers
    rsov_pkg::cfg_t      cfg_reg, cfg_next;

    logic                in_accept;
    logic                advance;
    logic                step;
    logic                core_valid;
    rsov_pkg::verdict_t  core_result;

    // the held word moves on when the result register is free or being emptied
    assign advance   = !out_valid_reg || !out_stall;
    assign step      = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step && core_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // register writes; the user must write only while the block is idle, the block does not enforce it
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (rsov_pkg::reg_idx_t'(cfg_index))
                rsov_pkg::REG_SIDE_MAP:     cfg_next.side_map     = cfg_data[15:0];
                rsov_pkg::REG_THRESHOLD:    cfg_next.threshold_cm = cfg_data[7:0];
                rsov_pkg::REG_MIN_READINGS: cfg_next.min_readings = cfg_data[7:0];
                rsov_pkg::REG_IDLE_LIMIT:   cfg_next.idle_limit   = cfg_data[7:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            cfg_reg.side_map      <= rsov_pkg::SIDE_MAP_RST;
            cfg_reg.threshold_cm  <= rsov_pkg::THRESHOLD_RST;
            cfg_reg.min_readings  <= rsov_pkg::MIN_READINGS_RST;
            cfg_reg.idle_limit    <= rsov_pkg::IDLE_LIMIT_RST;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_reg  <= req_type;
            sid_reg  <= sensor_id;
            dist_reg <= distance_cm;
        end
        if (step && core_valid)
        begin
            verdict_reg <= core_result;
        end
    end

    // session state and vote
    rsov_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .req_type     (req_reg),
        .sensor_id    (sid_reg),
        .distance_cm  (dist_reg),
        .cfg          (cfg_reg),
        .result_valid (core_valid),
        .result       (core_result)
    );

    assign out_valid     = out_valid_reg;
    assign front_blocked = verdict_reg.front_blocked;
    assign left_blocked  = verdict_reg.left_blocked;
    assign right_blocked = verdict_reg.right_blocked;
    assign timed_out     = verdict_reg.timed_out;

endmodule

`default_nettype wire

[hw/rtl/rsov_checker.sv]
// port-level checks for the range sensor obstacle vote block, bound to the top level
`default_nettype none

module rsov_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       req_type,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic       front_blocked,
    input wire logic       left_blocked,
    input wire logic       right_blocked,
    input wire logic       timed_out
);

    // a stalled result word stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    // a stalled result word keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable({front_blocked, left_blocked,
                                            right_blocked, timed_out}))
        else $error("result payload changed while stalled");

    // a fresh verdict comes from an accepted reading word
    a_verdict_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) && $past(rst_n, 2) |->
            $past(in_valid && !in_stall && req_type == rsov_pkg::REQ_READING, 2))
        else $error("verdict without a reading word");

    // a start word never produces a verdict
    a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && req_type == rsov_pkg::REQ_START |=> ##1 !$rose(out_valid))
        else $error("verdict produced by a start word");

endmodule

bind range_sensor_obstacle_vote rsov_checker u_rsov_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .front_blocked (front_blocked),
    .left_blocked  (left_blocked),
    .right_blocked (right_blocked),
    .timed_out     (timed_out)
);

`default_nettype wire
